// File: hdl/cron_calendar_matcher_top_defines.svh
// Assertion macros used by the calendar matcher checker.
`ifndef CRON_CALENDAR_MATCHER_TOP_DEFINES_SVH
`define CRON_CALENDAR_MATCHER_TOP_DEFINES_SVH

// Check a property on every rising edge outside of reset.
`define CCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define CCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ccm_pkg.sv
// Types, constants and helpers shared by the calendar matcher modules.
`default_nettype none

package ccm_pkg;

  localparam int MATCH_W = 16;

  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [13:0] YEAR_RESET = 14'd1970;
  localparam logic [13:0] YEAR_LAST  = 14'd9999;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [3:0]  MONTH_LAST  = 4'd12;
  localparam logic [3:0]  MONTH_FEB   = 4'd2;
  localparam logic [3:0]  MONTH_APR   = 4'd4;
  localparam logic [3:0]  MONTH_JUN   = 4'd6;
  localparam logic [3:0]  MONTH_SEP   = 4'd9;
  localparam logic [3:0]  MONTH_NOV   = 4'd11;
  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [4:0]  DAYS_28     = 5'd28;
  localparam logic [4:0]  DAYS_29     = 5'd29;
  localparam logic [4:0]  DAYS_30     = 5'd30;
  localparam logic [4:0]  DAYS_31     = 5'd31;
  localparam logic [4:0]  HOUR_LAST   = 5'd23;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [2:0]  WEEKDAY_RESET = 3'd4;
  localparam logic [2:0]  WEEKDAY_LAST  = 3'd6;
  localparam logic [6:0]  MOD100_RESET  = 7'd70;
  localparam logic [6:0]  MOD100_LAST   = 7'd99;
  localparam logic [8:0]  MOD400_RESET  = 9'd370;
  localparam logic [8:0]  MOD400_LAST   = 9'd399;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  row_index;
    logic [59:0] minute_mask;
    logic [23:0] hour_mask;
    logic [30:0] day_mask;
    logic [11:0] month_mask;
    logic [6:0]  weekday_mask;
  } ccm_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  weekday;
  } ccm_time_t;

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [2:0]         weekday;
    logic [MATCH_W-1:0] match_bits;
  } ccm_out_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] days;
    case (month)
      MONTH_FEB: days = leap ? DAYS_29 : DAYS_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_30;
      default: days = DAYS_31;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

// File: hdl/ccm_in_if.sv
// Request channel: valid, ready and one request payload.
`default_nettype none

interface ccm_in_if;
  logic             valid;
  logic             ready;
  ccm_pkg::ccm_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ccm_out_if.sv
// Result channel: valid, ready and one reported time with its row matches.
`default_nettype none

interface ccm_out_if;
  logic              valid;
  logic              ready;
  ccm_pkg::ccm_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ccm_calendar.sv
// Minute-resolution calendar counter with leap-year tracking and end-of-calendar hold.
`default_nettype none

module ccm_calendar (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          advance,
  output ccm_pkg::ccm_time_t now
);

  logic [13:0] year_r, year_nxt;
  logic [3:0]  month_r, month_nxt;
  logic [4:0]  day_r, day_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [2:0]  weekday_r, weekday_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [8:0]  mod400_r, mod400_nxt;
  logic        leap;
  logic        at_end;

  assign leap = ((year_r[1:0] == 2'd0) && (mod100_r != 7'd0)) || (mod400_r == 9'd0);

  assign at_end = (year_r == ccm_pkg::YEAR_LAST) && (month_r == ccm_pkg::MONTH_LAST) &&
                  (day_r == ccm_pkg::DAYS_31) && (hour_r == ccm_pkg::HOUR_LAST) &&
                  (minute_r == ccm_pkg::MINUTE_LAST);

  always_comb begin
    year_nxt    = year_r;
    month_nxt   = month_r;
    day_nxt     = day_r;
    hour_nxt    = hour_r;
    minute_nxt  = minute_r;
    weekday_nxt = weekday_r;
    mod100_nxt  = mod100_r;
    mod400_nxt  = mod400_r;
    if (advance && !at_end) begin
      if (minute_r != ccm_pkg::MINUTE_LAST) begin
        minute_nxt = minute_r + 6'd1;
      end else begin
        minute_nxt = 6'd0;
        if (hour_r != ccm_pkg::HOUR_LAST) begin
          hour_nxt = hour_r + 5'd1;
        end else begin
          hour_nxt = 5'd0;
          weekday_nxt = (weekday_r == ccm_pkg::WEEKDAY_LAST) ? 3'd0 : weekday_r + 3'd1;
          if (day_r != ccm_pkg::days_in_month(month_r, leap)) begin
            day_nxt = day_r + 5'd1;
          end else begin
            day_nxt = ccm_pkg::DAY_FIRST;
            if (month_r != ccm_pkg::MONTH_LAST) begin
              month_nxt = month_r + 4'd1;
            end else begin
              month_nxt  = ccm_pkg::MONTH_FIRST;
              year_nxt   = year_r + 14'd1;
              mod100_nxt = (mod100_r == ccm_pkg::MOD100_LAST) ? 7'd0 : mod100_r + 7'd1;
              mod400_nxt = (mod400_r == ccm_pkg::MOD400_LAST) ? 9'd0 : mod400_r + 9'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r    <= ccm_pkg::YEAR_RESET;
      month_r   <= ccm_pkg::MONTH_FIRST;
      day_r     <= ccm_pkg::DAY_FIRST;
      hour_r    <= 5'd0;
      minute_r  <= 6'd0;
      weekday_r <= ccm_pkg::WEEKDAY_RESET;
      mod100_r  <= ccm_pkg::MOD100_RESET;
      mod400_r  <= ccm_pkg::MOD400_RESET;
    end else begin
      year_r    <= year_nxt;
      month_r   <= month_nxt;
      day_r     <= day_nxt;
      hour_r    <= hour_nxt;
      minute_r  <= minute_nxt;
      weekday_r <= weekday_nxt;
      mod100_r  <= mod100_nxt;
      mod400_r  <= mod400_nxt;
    end
  end

  assign now.year    = year_r;
  assign now.month   = month_r;
  assign now.day     = day_r;
  assign now.hour    = hour_r;
  assign now.minute  = minute_r;
  assign now.weekday = weekday_r;

endmodule

`default_nettype wire

// File: hdl/ccm_row_table.sv
// Schedule row storage and parallel match of every row against the current time.
`default_nettype none

module ccm_row_table #(
  parameter int ROWS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  ccm_pkg::ccm_in_t                   wr_req,
  input  ccm_pkg::ccm_time_t                 now,
  output logic [ccm_pkg::MATCH_W-1:0]        match_bits
);

  localparam int STORED = (ROWS < ccm_pkg::MATCH_W) ? ROWS : ccm_pkg::MATCH_W;

  logic [STORED-1:0] hit;

  for (genvar r = 0; r < STORED; r++) begin : g_row
    logic [59:0] minutes_r;
    logic [23:0] hours_r;
    logic [30:0] days_r;
    logic [11:0] months_r;
    logic [6:0]  weekdays_r;
    logic        sel;

    assign sel = wr_en && (wr_req.row_index == 4'(r));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        minutes_r  <= '0;
        hours_r    <= '0;
        days_r     <= '0;
        months_r   <= '0;
        weekdays_r <= '0;
      end else if (sel) begin
        minutes_r  <= wr_req.minute_mask;
        hours_r    <= wr_req.hour_mask;
        days_r     <= wr_req.day_mask;
        months_r   <= wr_req.month_mask;
        weekdays_r <= wr_req.weekday_mask;
      end
    end

    assign hit[r] = minutes_r[now.minute] & hours_r[now.hour] &
                    days_r[now.day - ccm_pkg::DAY_FIRST] &
                    months_r[now.month - ccm_pkg::MONTH_FIRST] &
                    weekdays_r[now.weekday];
  end

  assign match_bits = ccm_pkg::MATCH_W'(hit);

endmodule

`default_nettype wire

// File: hdl/cron_calendar_matcher_top.sv
// Top level of the cron calendar matcher: request register, calendar, row table, result register.
`default_nettype none

// Cron calendar matcher. A write request stores the minute, hour, day, month and
// weekday masks of one schedule row; a tick request returns the current calendar
// time (starting 1970-01-01 00:00, Thursday) with a bitmap of the matching rows,
// then advances the clock by one minute, holding at 9999-12-31 23:59. Requests
// are taken one per cycle while the input is not stalled: each is held in the
// request register, and a tick's result is loaded into the result register as
// the tick leaves it and is offered from there until the sink takes it. Only a
// result the sink does not take holds the request register and stalls the
// input. All rows are compared at once; reset clears the row table, so an
// unwritten row never matches. Writes to a row at or above ROWS are dropped,
// and only the first sixteen rows report.
module cron_calendar_matcher_top #(
  parameter int ROWS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ccm_in_if.sink    in_chan,
  ccm_out_if.source out_chan
);

  logic                 s1_valid_r, s1_valid_nxt;
  ccm_pkg::ccm_in_t     s1_req_r;
  logic                 out_valid_r, out_valid_nxt;
  ccm_pkg::ccm_out_t    out_req_r;
  logic                 in_acc;
  logic                 s1_tick;
  logic                 s1_go;
  logic                 wr_en;
  logic                 advance;
  ccm_pkg::ccm_time_t   now;
  logic [ccm_pkg::MATCH_W-1:0] match_bits;

  assign s1_tick = (s1_req_r.cmd == ccm_pkg::CMD_TICK);
  assign s1_go   = s1_valid_r && (!s1_tick || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_go;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign wr_en   = s1_go && (s1_req_r.cmd == ccm_pkg::CMD_WRITE);
  assign advance = s1_go && s1_tick;

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_chan.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_req_r.year       <= now.year;
      out_req_r.month      <= now.month;
      out_req_r.day        <= now.day;
      out_req_r.hour       <= now.hour;
      out_req_r.minute     <= now.minute;
      out_req_r.weekday    <= now.weekday;
      out_req_r.match_bits <= match_bits;
    end
  end

  ccm_calendar u_calendar (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .now     (now)
  );

  ccm_row_table #(
    .ROWS (ROWS)
  ) u_row_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_req     (s1_req_r),
    .now        (now),
    .match_bits (match_bits)
  );

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_req_r;

endmodule

`default_nettype wire

// File: hdl/ccm_checker.sv
// Port-level checker for the cron calendar matcher, bound to the top level.
`default_nettype none
`include "cron_calendar_matcher_top_defines.svh"

module ccm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_cmd,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input ccm_pkg::ccm_out_t out_payload
);

  logic out_stall;
  logic tick_acc;
  logic time_ok;

  assign out_stall = out_valid && !out_ready;
  assign tick_acc  = in_valid && in_ready && (in_cmd == ccm_pkg::CMD_TICK);
  assign time_ok   = (out_payload.minute <= ccm_pkg::MINUTE_LAST) &&
                     (out_payload.hour <= ccm_pkg::HOUR_LAST) &&
                     (out_payload.weekday <= ccm_pkg::WEEKDAY_LAST) &&
                     (out_payload.month >= ccm_pkg::MONTH_FIRST) &&
                     (out_payload.month <= ccm_pkg::MONTH_LAST) &&
                     (out_payload.day >= ccm_pkg::DAY_FIRST);

  `CCM_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  `CCM_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_payload),
              "stalled result changed")

  `CCM_ASSERT(a_stall_cause, clk, rst_n, !in_ready |-> out_stall,
              "input stalled without a blocked result")

  `CCM_ASSERT(a_result_source, clk, rst_n, $rose(out_valid) |-> $past(tick_acc, 2),
              "result without a tick request")

  `CCM_ASSERT(a_time_range, clk, rst_n, out_valid |-> time_ok, "reported time out of range")

endmodule

bind cron_calendar_matcher_top ccm_checker u_ccm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_cmd      (in_chan.payload.cmd),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_payload (out_chan.payload)
);

`default_nettype wire
